### rtl/core/ctsf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ctsf_pkg;

    localparam int FRAC_BITS_DEF   = 16;
    localparam int QUEUE_DEPTH_DEF = 2;

    localparam int IN_W        = 18;
    localparam int OUT_W       = 26;
    localparam int NODE_W      = 4;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 88;

    localparam longint OUT_MAX = 64'sd33554431;
    localparam longint OUT_MIN = -64'sd33554432;

    // node numbering: vertices 0..2, edge nodes 3..8, center node 9
    localparam logic [NODE_W-1:0] NODE_V0  = 4'd0;
    localparam logic [NODE_W-1:0] NODE_V1  = 4'd1;
    localparam logic [NODE_W-1:0] NODE_V2  = 4'd2;
    localparam logic [NODE_W-1:0] NODE_E3  = 4'd3;
    localparam logic [NODE_W-1:0] NODE_E4  = 4'd4;
    localparam logic [NODE_W-1:0] NODE_E5  = 4'd5;
    localparam logic [NODE_W-1:0] NODE_E6  = 4'd6;
    localparam logic [NODE_W-1:0] NODE_E7  = 4'd7;
    localparam logic [NODE_W-1:0] NODE_E8  = 4'd8;
    localparam logic [NODE_W-1:0] NODE_CTR = 4'd9;

    // coordinate magnitude base: larger of the fraction width and the input range
    function automatic int base_w(input int frac);
        return (frac > IN_W - 1) ? frac : IN_W - 1;
    endfunction

    // rounded square / cross product of two coordinates
    function automatic int sq_w(input int frac);
        return 2 * IN_W - frac;
    endfunction

    // queue record: c, e, cc, ee, ce (c lowest)
    function automatic int rec_w(input int frac);
        return 2 * IN_W + 3 * sq_w(frac);
    endfunction

    // factors of the shape-function products
    function automatic int fac_w(input int frac);
        return base_w(frac) + 6;
    endfunction

    // rounded inner product
    function automatic int inn_w(input int frac);
        return 2 * base_w(frac) - frac + 10;
    endfunction

    // derivative sums
    function automatic int der_w(input int frac);
        return ((sq_w(frac) > base_w(frac)) ? sq_w(frac) : base_w(frac)) + 11;
    endfunction

endpackage

`default_nettype wire

### rtl/core/ctsf_front.sv
`timescale 1ns / 1ps
`default_nettype none

module ctsf_front
    import ctsf_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    input  wire logic [IN_TDATA_W-1:0]          s_axis_tdata,  // csi[17:0], eta[35:18]
    output logic                                o_push,
    output logic [rec_w(FRAC_BITS)-1:0]         o_rec,
    input  wire logic                           i_q_ready
);

    localparam int SW  = sq_w(FRAC_BITS);
    localparam int PRD = 2 * IN_W;
    localparam logic signed [PRD-1:0] HALF    = PRD'(64'sd1 <<< (FRAC_BITS - 1));
    localparam logic signed [PRD-1:0] HALF_M1 = HALF - PRD'(1);

    logic                 r_valid;
    logic signed [IN_W-1:0] r_c, r_e;
    logic signed [SW-1:0] r_cc, r_ee, r_ce;
    logic                 accept;
    logic signed [IN_W-1:0] in_c, in_e;

    // product of two coordinates, rounded to nearest, ties away from zero
    function automatic logic signed [SW-1:0] rnd_mul(
        input logic signed [IN_W-1:0] a,
        input logic signed [IN_W-1:0] b
    );
        logic signed [PRD-1:0] p;
        logic signed [PRD-1:0] t;
        p = a * b;
        t = p[PRD-1] ? (p + HALF_M1) : (p + HALF);
        t = t >>> FRAC_BITS;
        return t[SW-1:0];
    endfunction

    assign in_c          = s_axis_tdata[IN_W-1:0];
    assign in_e          = s_axis_tdata[2*IN_W-1:IN_W];
    assign s_axis_tready = !r_valid || i_q_ready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign o_push        = r_valid && i_q_ready;
    assign o_rec         = {r_ce, r_ee, r_cc, r_e, r_c};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_c  <= in_c;
            r_e  <= in_e;
            r_cc <= rnd_mul(in_c, in_c);
            r_ee <= rnd_mul(in_e, in_e);
            r_ce <= rnd_mul(in_c, in_e);
        end
    end

endmodule

`default_nettype wire

### rtl/core/ctsf_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module ctsf_queue
    import ctsf_pkg::*;
#(
    parameter int WIDTH = rec_w(FRAC_BITS_DEF),
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_ready,
    input  wire logic             i_pop,
    output logic                  o_valid,
    output logic [WIDTH-1:0]      o_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL      = CW'(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wptr, r_rptr;
    logic [CW-1:0]    r_count;

    assign o_ready = (r_count != FULL);
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == LAST_SLOT) ? '0 : r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == LAST_SLOT) ? '0 : r_rptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

### rtl/core/ctsf_back.sv
`timescale 1ns / 1ps
`default_nettype none

module ctsf_back
    import ctsf_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_q_valid,
    input  wire logic [rec_w(FRAC_BITS)-1:0]  i_q_data,
    output logic                              o_q_pop,
    output logic                              m_axis_tvalid,
    input  wire logic                         m_axis_tready,
    output logic [OUT_TDATA_W-1:0]            m_axis_tdata,
    output logic                              m_axis_tlast
);

    localparam int SW   = sq_w(FRAC_BITS);
    localparam int FW   = fac_w(FRAC_BITS);
    localparam int IW   = inn_w(FRAC_BITS);
    localparam int DW   = der_w(FRAC_BITS);
    localparam int P1W  = 2 * FW;
    localparam int P2W  = FW + IW;
    localparam int PADW = OUT_TDATA_W - NODE_W - 3 * OUT_W;

    localparam logic signed [FW-1:0] F_ONE = FW'(64'sd1 <<< FRAC_BITS);
    localparam logic signed [FW-1:0] F_TWO = FW'(64'sd2 <<< FRAC_BITS);

    localparam logic signed [P1W-1:0] H1    = P1W'(64'sd1 <<< (FRAC_BITS - 1));
    localparam logic signed [P1W-1:0] H1_M1 = H1 - P1W'(1);
    localparam logic signed [P2W-1:0] H2F   = P2W'(64'sd1 <<< (FRAC_BITS - 1));
    localparam logic signed [P2W-1:0] H2F_M1 = H2F - P2W'(1);
    localparam logic signed [P2W-1:0] H2H   = P2W'(64'sd1 <<< FRAC_BITS);
    localparam logic signed [P2W-1:0] H2H_M1 = H2H - P2W'(1);

    localparam logic signed [P2W-1:0] SMAX_P = P2W'(OUT_MAX);
    localparam logic signed [P2W-1:0] SMIN_P = P2W'(OUT_MIN);
    localparam logic signed [DW-1:0]  SMAX_D = DW'(OUT_MAX);
    localparam logic signed [DW-1:0]  SMIN_D = DW'(OUT_MIN);

    localparam logic signed [DW-1:0] D_ONE = DW'(64'sd1 <<< FRAC_BITS);
    localparam logic signed [DW-1:0] K2   = DW'(2);
    localparam logic signed [DW-1:0] K9   = DW'(9);
    localparam logic signed [DW-1:0] K11  = DW'(11);
    localparam logic signed [DW-1:0] K18  = DW'(18);
    localparam logic signed [DW-1:0] K27  = DW'(27);
    localparam logic signed [DW-1:0] K36  = DW'(36);
    localparam logic signed [DW-1:0] K45  = DW'(45);
    localparam logic signed [DW-1:0] K54  = DW'(54);
    localparam logic signed [DW-1:0] K72  = DW'(72);
    localparam logic signed [DW-1:0] K81  = DW'(81);
    localparam logic signed [DW-1:0] K90  = DW'(90);
    localparam logic signed [DW-1:0] K108 = DW'(108);

    function automatic logic [OUT_W-1:0] sat_p(input logic signed [P2W-1:0] v);
        logic [OUT_W-1:0] r;
        if (v > SMAX_P) begin
            r = SMAX_P[OUT_W-1:0];
        end else if (v < SMIN_P) begin
            r = SMIN_P[OUT_W-1:0];
        end else begin
            r = v[OUT_W-1:0];
        end
        return r;
    endfunction

    function automatic logic [OUT_W-1:0] sat_d(input logic signed [DW-1:0] v);
        logic [OUT_W-1:0] r;
        if (v > SMAX_D) begin
            r = SMAX_D[OUT_W-1:0];
        end else if (v < SMIN_D) begin
            r = SMIN_D[OUT_W-1:0];
        end else begin
            r = v[OUT_W-1:0];
        end
        return r;
    endfunction

    // halve with ties away from zero
    function automatic logic signed [DW-1:0] half_rnd(input logic signed [DW-1:0] v);
        logic signed [DW-1:0] t;
        t = v[DW-1] ? v : (v + DW'(1));
        return t >>> 1;
    endfunction

    // pipeline advances whenever the output register is free or drained
    logic en;

    // issue: node sequencer over the queue head
    logic [NODE_W-1:0]      r_node;
    logic                   issue;
    logic signed [IN_W-1:0] q_c, q_e;
    logic signed [SW-1:0]   q_cc, q_ee, q_ce;

    logic signed [FW-1:0] fc, fe, fl, c3, e3, l3;
    logic signed [FW-1:0] c3m1, c3m2, e3m1, e3m2, l3m1, l3m2;
    logic signed [FW-1:0] c9, l9, c27;
    logic signed [DW-1:0] dc, de, dl_one, dcc, dee, dce;

    logic signed [FW-1:0] sel_a, sel_b, sel_o;
    logic                 sel_half;
    logic signed [DW-1:0] sel_dc, sel_de;
    logic                 sel_dhalf;

    // stage 1: selected factors and raw derivative sums
    logic                   r_s1_valid;
    logic [NODE_W-1:0]      r_s1_node;
    logic signed [FW-1:0]   r_s1_a, r_s1_b, r_s1_o;
    logic                   r_s1_half, r_s1_dhalf;
    logic signed [DW-1:0]   r_s1_dc, r_s1_de;

    // stage 2: rounded inner product, finished derivatives
    logic signed [P1W-1:0]  p1, t1;
    logic signed [DW-1:0]   dc_fin, de_fin;
    logic                   r_s2_valid;
    logic [NODE_W-1:0]      r_s2_node;
    logic signed [FW-1:0]   r_s2_o;
    logic signed [IW-1:0]   r_s2_inner;
    logic                   r_s2_half;
    logic [OUT_W-1:0]       r_s2_dc, r_s2_de;

    // stage 3: output register
    logic signed [P2W-1:0]  p2, t2;
    logic                   r_o_valid;
    logic [NODE_W-1:0]      r_o_node;
    logic [OUT_W-1:0]       r_o_val, r_o_dc, r_o_de;

    assign en      = !r_o_valid || m_axis_tready;
    assign issue   = en && i_q_valid;
    assign o_q_pop = issue && (r_node == NODE_CTR);

    assign q_c  = i_q_data[IN_W-1:0];
    assign q_e  = i_q_data[2*IN_W-1:IN_W];
    assign q_cc = i_q_data[2*IN_W+SW-1:2*IN_W];
    assign q_ee = i_q_data[2*IN_W+2*SW-1:2*IN_W+SW];
    assign q_ce = i_q_data[2*IN_W+3*SW-1:2*IN_W+2*SW];

    always_comb begin
        fc   = FW'(q_c);
        fe   = FW'(q_e);
        fl   = F_ONE - fc - fe;
        c3   = (fc <<< 1) + fc;
        e3   = (fe <<< 1) + fe;
        l3   = (fl <<< 1) + fl;
        c3m1 = c3 - F_ONE;
        c3m2 = c3 - F_TWO;
        e3m1 = e3 - F_ONE;
        e3m2 = e3 - F_TWO;
        l3m1 = l3 - F_ONE;
        l3m2 = l3 - F_TWO;
        c9   = (fc <<< 3) + fc;
        l9   = (fl <<< 3) + fl;
        c27  = (c9 <<< 1) + c9;

        dc     = DW'(q_c);
        de     = DW'(q_e);
        dl_one = D_ONE;
        dcc    = DW'(q_cc);
        dee    = DW'(q_ee);
        dce    = DW'(q_ce);
    end

    // per-node factor selection and derivative combination
    always_comb begin
        sel_a     = l3m1;
        sel_b     = l3m2;
        sel_o     = fl;
        sel_half  = 1'b1;
        sel_dc    = '0;
        sel_de    = '0;
        sel_dhalf = 1'b1;
        unique case (r_node)
            NODE_V0: begin
                sel_dc = '0 - (K27 * dee + K54 * dce - K36 * de + K27 * dcc - K36 * dc
                               + K11 * dl_one);
                sel_de = sel_dc;
            end
            NODE_V1: begin
                sel_a  = c3m1;
                sel_b  = c3m2;
                sel_o  = fc;
                sel_dc = K27 * dcc - K18 * dc + K2 * dl_one;
            end
            NODE_V2: begin
                sel_a  = e3m1;
                sel_b  = e3m2;
                sel_o  = fe;
                sel_de = K27 * dee - K18 * de + K2 * dl_one;
            end
            NODE_E3: begin
                sel_a  = fl;
                sel_b  = l3m1;
                sel_o  = c9;
                sel_dc = K27 * dee + K108 * dce - K45 * de + K81 * dcc - K90 * dc
                         + K18 * dl_one;
                sel_de = K54 * dce + K54 * dcc - K45 * dc;
            end
            NODE_E4: begin
                sel_a  = fl;
                sel_b  = c3m1;
                sel_o  = c9;
                sel_dc = '0 - (K54 * dce - K9 * de + K81 * dcc - K72 * dc + K9 * dl_one);
                sel_de = K9 * dc - K27 * dcc;
            end
            NODE_E5: begin
                sel_a  = fe;
                sel_b  = c3m1;
                sel_o  = c9;
                sel_dc = K54 * dce - K9 * de;
                sel_de = K27 * dcc - K9 * dc;
            end
            NODE_E6: begin
                sel_a  = fe;
                sel_b  = e3m1;
                sel_o  = c9;
                sel_dc = K27 * dee - K9 * de;
                sel_de = K54 * dce - K9 * dc;
            end
            NODE_E7: begin
                sel_a  = fe;
                sel_b  = e3m1;
                sel_o  = l9;
                sel_dc = K9 * de - K27 * dee;
                sel_de = '0 - (K81 * dee + K54 * dce - K72 * de - K9 * dc + K9 * dl_one);
            end
            NODE_E8: begin
                sel_a  = fe;
                sel_b  = l3m1;
                sel_o  = l9;
                sel_dc = K54 * dee + K54 * dce - K45 * de;
                sel_de = K81 * dee + K108 * dce - K90 * de + K27 * dcc - K45 * dc
                         + K18 * dl_one;
            end
            NODE_CTR: begin
                sel_a     = fl;
                sel_b     = fe;
                sel_o     = c27;
                sel_half  = 1'b0;
                sel_dc    = K27 * de - K54 * dce - K27 * dee;
                sel_de    = K27 * dc - K54 * dce - K27 * dcc;
                sel_dhalf = 1'b0;
            end
            default: begin
                sel_a = l3m1;
            end
        endcase
    end

    always_comb begin
        p1     = r_s1_a * r_s1_b;
        t1     = p1[P1W-1] ? (p1 + H1_M1) : (p1 + H1);
        t1     = t1 >>> FRAC_BITS;
        dc_fin = r_s1_dhalf ? half_rnd(r_s1_dc) : r_s1_dc;
        de_fin = r_s1_dhalf ? half_rnd(r_s1_de) : r_s1_de;
    end

    // outer product: /2 folded into the shift for all but the center node
    always_comb begin
        p2 = r_s2_o * r_s2_inner;
        if (r_s2_half) begin
            t2 = p2[P2W-1] ? (p2 + H2H_M1) : (p2 + H2H);
            t2 = t2 >>> (FRAC_BITS + 1);
        end else begin
            t2 = p2[P2W-1] ? (p2 + H2F_M1) : (p2 + H2F);
            t2 = t2 >>> FRAC_BITS;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node     <= NODE_V0;
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else if (en) begin
            if (issue) begin
                r_node <= (r_node == NODE_CTR) ? NODE_V0 : r_node + 1'b1;
            end
            r_s1_valid <= i_q_valid;
            r_s2_valid <= r_s1_valid;
            r_o_valid  <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_node  <= r_node;
            r_s1_a     <= sel_a;
            r_s1_b     <= sel_b;
            r_s1_o     <= sel_o;
            r_s1_half  <= sel_half;
            r_s1_dc    <= sel_dc;
            r_s1_de    <= sel_de;
            r_s1_dhalf <= sel_dhalf;

            r_s2_node  <= r_s1_node;
            r_s2_o     <= r_s1_o;
            r_s2_inner <= t1[IW-1:0];
            r_s2_half  <= r_s1_half;
            r_s2_dc    <= sat_d(dc_fin);
            r_s2_de    <= sat_d(de_fin);

            r_o_node   <= r_s2_node;
            r_o_val    <= sat_p(t2);
            r_o_dc     <= r_s2_dc;
            r_o_de     <= r_s2_de;
        end
    end

    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tlast  = (r_o_node == NODE_CTR);
    assign m_axis_tdata  = {{PADW{1'b0}}, r_o_de, r_o_dc, r_o_val, r_o_node};

endmodule

`default_nettype wire

### rtl/core/cubic_triangle_shape_functions_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Ten-node cubic Lagrange triangle evaluator. Each request on the slave
// stream is one point (csi, eta) of the reference triangle in signed fixed
// point with FRAC_BITS fraction bits; for it the master stream returns ten
// results in node order 0..9, each carrying the node index, the shape
// function value N and the partials dN/dcsi and dN/deta, all in the same
// fixed-point format and clamped to 26 bits signed. tlast marks node 9.
// Throughput: one result per cycle when the output is not stalled and the
// queue holds a point; the node sequencer in the back end, which feeds one
// inner and one outer multiplier with one node per cycle, sets that figure.
// The first result reaches tvalid after the point has passed the front
// register, the queue write and the three back-end stages. The front end
// computes the squares and the cross product of the coordinates once per
// point and parks them in a small queue, so it can take the next point
// while the back end is still working through the nodes of the current one.

module cubic_triangle_shape_functions_core
    import ctsf_pkg::*;
#(
    parameter int FRAC_BITS   = FRAC_BITS_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,   // csi_coord[17:0], eta_coord[35:18]
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata,   // node_index[3:0], shape_value[29:4],
                                                        // deriv_csi[55:30], deriv_eta[81:56]
    output logic                        m_axis_tlast    // last_node
);

    localparam int RW = rec_w(FRAC_BITS);

    logic          push, q_ready, q_valid, q_pop;
    logic [RW-1:0] front_rec, q_rec;

    // front: accept point, form cc, ee, ce
    ctsf_front #(
        .FRAC_BITS(FRAC_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .o_push       (push),
        .o_rec        (front_rec),
        .i_q_ready    (q_ready)
    );

    // decouples point intake from the back end's sweep over the ten nodes
    ctsf_queue #(
        .WIDTH(RW),
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_data (front_rec),
        .o_ready(q_ready),
        .i_pop  (q_pop),
        .o_valid(q_valid),
        .o_data (q_rec)
    );

    // back: per-node products, derivatives, saturation, output register
    ctsf_back #(
        .FRAC_BITS(FRAC_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (q_valid),
        .i_q_data     (q_rec),
        .o_q_pop      (q_pop),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast)
    );

endmodule

`default_nettype wire
